// ===== rtl/core/pss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants for the format spec scanner
// Scan phases, character codes and the per-word step result.
// ----------------------------------------------------------------------------
package pss_pkg;

  // Scan phase, one-hot
  typedef enum logic [7:0] {
    PH_TEXT     = 8'b0000_0001,
    PH_PCT      = 8'b0000_0010,
    PH_AT       = 8'b0000_0100,
    PH_FLAGS    = 8'b0000_1000,
    PH_DIGITS   = 8'b0001_0000,
    PH_AFTERNUM = 8'b0010_0000,
    PH_DOT      = 8'b0100_0000,
    PH_LEN      = 8'b1000_0000
  } phase_t;

  // Result kinds
  localparam logic KIND_STAR = 1'b0;
  localparam logic KIND_CONV = 1'b1;

  // Character codes
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_AT    = 8'h40;  // '@'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_QUOTE = 8'h27;  // '\''
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_LC_L  = 8'h6C;  // 'l'
  localparam logic [7:0] CH_LC_H  = 8'h68;  // 'h'
  localparam logic [7:0] CH_UC_L  = 8'h4C;  // 'L'
  localparam logic [7:0] CH_LC_Z  = 8'h7A;  // 'z'
  localparam logic [7:0] CH_LC_T  = 8'h74;  // 't'
  localparam logic [7:0] CH_LC_J  = 8'h6A;  // 'j'
  localparam logic [7:0] CH_LC_Q  = 8'h71;  // 'q'

  localparam logic [15:0] STAR_LEN = 16'd2;

  // Outcome of scanning one byte
  typedef struct packed {
    phase_t      phase_nxt;
    logic        start_load;   // record current position as spec start
    logic        res_vld;
    logic        kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [7:0]  conv;
  } step_t;

endpackage

// ===== rtl/core/pss_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_step: one-byte scan step
// Resolves the phase chain for one byte (pct -> flags -> width -> dot -> len) and
// builds the optional star or conversion result.
// ----------------------------------------------------------------------------
module pss_step (
  input  pss_pkg::phase_t phase,
  input  logic [7:0]      char_byte,
  input  logic [15:0]     pos,
  input  logic [15:0]     start,
  output pss_pkg::step_t  step
);

  logic        is_digit;
  logic        is_flag;
  logic        is_lenmod;
  logic        do_flags;
  logic        do_after;
  logic        do_len;
  logic [16:0] len_full;
  logic [15:0] conv_len;

  // Character classes
  assign is_digit  = (char_byte >= pss_pkg::CH_ZERO) && (char_byte <= pss_pkg::CH_NINE);
  assign is_flag   = char_byte inside {pss_pkg::CH_MINUS, pss_pkg::CH_PLUS, pss_pkg::CH_SPACE,
                                       pss_pkg::CH_ZERO, pss_pkg::CH_HASH, pss_pkg::CH_QUOTE};
  assign is_lenmod = char_byte inside {pss_pkg::CH_LC_L, pss_pkg::CH_LC_H, pss_pkg::CH_UC_L,
                                       pss_pkg::CH_LC_Z, pss_pkg::CH_LC_T, pss_pkg::CH_LC_J,
                                       pss_pkg::CH_LC_Q};

  // Spec length, saturating
  assign len_full = {1'b0, pos} - {1'b0, start} + 17'd1;
  always_comb begin
    if (pos < start) begin
      conv_len = 16'd1;
    end else if (len_full[16]) begin
      conv_len = 16'hFFFF;
    end else begin
      conv_len = len_full[15:0];
    end
  end

  // Phase chain
  always_comb begin
    step            = '0;
    step.phase_nxt  = pss_pkg::PH_TEXT;
    step.offset     = pos;
    step.length     = pss_pkg::STAR_LEN;
    step.conv       = pss_pkg::CH_D;
    step.kind       = pss_pkg::KIND_STAR;
    do_flags        = 1'b0;
    do_after        = 1'b0;
    do_len          = 1'b0;

    case (phase)
      pss_pkg::PH_PCT: begin
        if (char_byte == pss_pkg::CH_PCT) begin
          step.phase_nxt = pss_pkg::PH_TEXT;
        end else if (char_byte == pss_pkg::CH_AT) begin
          step.phase_nxt = pss_pkg::PH_AT;
        end else begin
          do_flags = 1'b1;
        end
      end
      pss_pkg::PH_AT: begin
        step.phase_nxt = pss_pkg::PH_AT;
        if (char_byte == pss_pkg::CH_AT) begin
          step.phase_nxt = pss_pkg::PH_FLAGS;
        end else if (char_byte == pss_pkg::CH_STAR) begin
          step.res_vld = 1'b1;
        end
      end
      pss_pkg::PH_FLAGS: begin
        do_flags = 1'b1;
      end
      pss_pkg::PH_DIGITS: begin
        if (is_digit) begin
          step.phase_nxt = pss_pkg::PH_DIGITS;
        end else begin
          do_after = 1'b1;
        end
      end
      pss_pkg::PH_AFTERNUM: begin
        do_after = 1'b1;
      end
      pss_pkg::PH_DOT: begin
        if (char_byte == pss_pkg::CH_STAR) begin
          step.res_vld   = 1'b1;
          step.phase_nxt = pss_pkg::PH_AFTERNUM;
        end else if (is_digit) begin
          step.phase_nxt = pss_pkg::PH_DIGITS;
        end else begin
          do_after = 1'b1;
        end
      end
      pss_pkg::PH_LEN: begin
        do_len = 1'b1;
      end
      default: begin
        // text, and any unused code
        if (char_byte == pss_pkg::CH_PCT) begin
          step.start_load = 1'b1;
          step.phase_nxt  = pss_pkg::PH_PCT;
        end
      end
    endcase

    // flags / width star / width digits
    if (do_flags) begin
      if (is_flag) begin
        step.phase_nxt = pss_pkg::PH_FLAGS;
      end else if (char_byte == pss_pkg::CH_STAR) begin
        step.res_vld   = 1'b1;
        step.phase_nxt = pss_pkg::PH_AFTERNUM;
      end else if (is_digit) begin
        step.phase_nxt = pss_pkg::PH_DIGITS;
      end else begin
        do_after = 1'b1;
      end
    end

    // precision dot
    if (do_after) begin
      if (char_byte == pss_pkg::CH_DOT) begin
        step.phase_nxt = pss_pkg::PH_DOT;
      end else begin
        do_len = 1'b1;
      end
    end

    // length modifiers and conversion
    if (do_len) begin
      if (is_lenmod) begin
        step.phase_nxt = pss_pkg::PH_LEN;
      end else if (char_byte == pss_pkg::CH_M) begin
        step.phase_nxt = pss_pkg::PH_TEXT;
      end else begin
        step.res_vld   = 1'b1;
        step.kind      = pss_pkg::KIND_CONV;
        step.offset    = start;
        step.length    = conv_len;
        step.conv      = char_byte;
        step.phase_nxt = pss_pkg::PH_TEXT;
      end
    end
  end

endmodule

// ===== rtl/core/printf_spec_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_spec_scanner: printf format specifier scanner
// Scans a format string a byte per word and emits one word per argument.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    char_byte[7:0], last_byte
//  out_     output     out_valid/out_ready  arg_kind, spec_offset[15:0],
//                                           spec_length[15:0], conv_char[7:0]
//
//  One byte per cycle sustained while out_ready keeps up; each byte waits in the
//  input register and its result (if any) moves on to the output register.
//  Reset (synchronous, rst_n low) empties both registers and puts the scanner
//  in the text phase at position zero.
//  A stalled output holds the word in the input register and drops in_ready.
// ----------------------------------------------------------------------------
module printf_spec_scanner #(
  parameter int MAX_FORMAT_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_arg_kind,
  output logic [15:0] out_spec_offset,
  output logic [15:0] out_spec_length,
  output logic [7:0]  out_conv_char
);

  localparam logic [15:0] POS_MAX = 16'(MAX_FORMAT_LEN);

  logic            in_vld_r;
  logic [7:0]      char_r;
  logic            last_r;
  pss_pkg::phase_t phase_r;
  logic [15:0]     pos_r;
  logic [15:0]     start_r;
  logic            out_vld_r;
  logic            kind_r;
  logic [15:0]     offset_r;
  logic [15:0]     length_r;
  logic [7:0]      conv_r;
  logic            adv;
  pss_pkg::step_t  step;

  // Scan stage moves when it holds a word and the result slot can take one
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  pss_step u_step (
    .phase     (phase_r),
    .char_byte (char_r),
    .pos       (pos_r),
    .start     (start_r),
    .step      (step)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      char_r <= in_char_byte;
      last_r <= in_last_byte;
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pss_pkg::PH_TEXT;
      pos_r   <= '0;
      start_r <= '0;
    end else if (adv) begin
      if (last_r) begin
        phase_r <= pss_pkg::PH_TEXT;
        pos_r   <= '0;
        start_r <= '0;
      end else begin
        phase_r <= step.phase_nxt;
        if (step.start_load) begin
          start_r <= pos_r;
        end
        if (pos_r < POS_MAX) begin
          pos_r <= pos_r + 16'd1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= step.res_vld;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (adv && step.res_vld) begin
      kind_r   <= step.kind;
      offset_r <= step.offset;
      length_r <= step.length;
      conv_r   <= step.conv;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_arg_kind    = kind_r;
  assign out_spec_offset = offset_r;
  assign out_spec_length = length_r;
  assign out_conv_char   = conv_r;

`ifndef SYNTHESIS
  // star words always look like "%d"
  a_star_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_arg_kind == pss_pkg::KIND_STAR) |->
      (out_spec_length == pss_pkg::STAR_LEN) && (out_conv_char == pss_pkg::CH_D))
    else $error("star word with wrong length or conversion");

  // final byte returns the scanner to its reset state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last_r |=> (pos_r == 16'd0) && (phase_r == pss_pkg::PH_TEXT))
    else $error("scanner not cleared after final byte");

  // a conversion word never reaches past the current position
  a_conv_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step.res_vld && (step.kind == pss_pkg::KIND_CONV) |->
      (step.offset == start_r) && (step.length != 16'd0) && (start_r <= pos_r))
    else $error("conversion word out of bounds");
`endif

endmodule
